### design/bpa_pkg.sv
// Package: types and constants for the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int MaxPages = 4096;
  localparam int WordBits = 32;
  localparam int MapWords = MaxPages / WordBits;
  localparam int AddrW = $clog2(MapWords);
  localparam int BitW = $clog2(WordBits);
  localparam int CntW = 13;
  localparam int PageW = 12;

  localparam logic [2:0] ReqAlloc = 3'd0;
  localparam logic [2:0] ReqFree = 3'd1;
  localparam logic [2:0] ReqTest = 3'd2;
  localparam logic [2:0] ReqFind = 3'd3;
  localparam logic [2:0] ReqInit = 3'd4;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StRej = 2'd2;

  localparam logic CfgTotal = 1'b0;
  localparam logic CfgReserved = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [PageW-1:0] page_index;
    logic [CntW-1:0] num_pages;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [PageW-1:0] result_page;
    logic page_used;
    logic [CntW-1:0] used_count;
  } out_word_t;
endpackage

### design/bitmap_page_allocator.sv
// Top level: bitmap page allocator with bit-serial first-fit scan.
`timescale 1ns / 1ps
// One request per start pulse; busy stays high until the result word shows. The
// map is a 128x32 RAM walked one page per cycle, apart from a pause to read each
// new word, by one read-modify-write unit. A taken request passes a check
// state, then the walk if it has one, then a done state that registers the
// result word. A scan (alloc, find) reads each word (read and wait states) and
// then tests its pages one at a time; alloc then marks its run, and free clears
// its range, by reading each word, changing its pages and writing it back. Init
// writes every word. Test reads the word that holds its page; rejected requests
// go straight from the check state to done. A clearing pass over all 128 words
// runs after reset with busy high. Results show for one cycle on out_valid and cannot be stalled.
module bitmap_page_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  bpa_pkg::in_word_t         in_word,
  output logic                      out_valid,
  output bpa_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bpa_pkg::CntW-1:0]  cfg_data
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHECK, S_RD, S_WAIT, S_BIT, S_WB, S_FILL, S_DONE
  } state_t;

  // phase of a request: scan (alloc/find), test (test), mark (alloc) or clear (free)
  typedef enum logic [1:0] {P_SCAN, P_MARK, P_FREE, P_TEST} phase_t;

  state_t state_r;
  phase_t phase_r;
  logic [2:0] req_r;
  logic [CntW-1:0] cnt_r, run_r, tot_r, cfg_tot_r, cfg_res_r, used_r;
  logic [CntW-1:0] p_r, stop_r;
  logic [AddrW-1:0] wb_addr_r;
  logic [PageW-1:0] pidx_r;
  logic [WordBits-1:0] word_r;
  logic [AddrW:0] clr_r;
  logic [1:0] st_r;
  logic [PageW-1:0] rpage_r;
  logic pused_r, wb_dirty_r;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  bpa_ram #(.Width(WordBits), .Depth(MapWords)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [CntW-1:0] tot_eff, res_eff, init_lim, fill_base;
  assign tot_eff = (cfg_tot_r > CntW'(MaxPages)) ? CntW'(MaxPages) : cfg_tot_r;
  assign res_eff = (cfg_res_r > CntW'(MaxPages)) ? CntW'(MaxPages) : cfg_res_r;
  assign init_lim = (res_eff < tot_r) ? res_eff : tot_r;
  assign fill_base = {1'b0, clr_r[AddrW-1:0], BitW'(0)};

  logic [WordBits-1:0] fill_word;
  always_comb begin
    for (int b = 0; b < WordBits; b++)
      fill_word[b] = (fill_base + CntW'(b)) < init_lim;
  end

  logic [BitW-1:0] bsel;
  logic cur_bit;
  assign bsel = p_r[BitW-1:0];
  assign cur_bit = word_r[bsel];

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = word_r;
    ram_addr = p_r[BitW +: AddrW];
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_wdata = '0;
        ram_addr = clr_r[AddrW-1:0];
      end
      S_FILL: begin
        ram_we = 1'b1;
        ram_wdata = fill_word;
        ram_addr = clr_r[AddrW-1:0];
      end
      S_WB: begin
        ram_we = wb_dirty_r;
        ram_addr = wb_addr_r;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  logic [CntW:0] sum_w;
  assign sum_w = {1'b0, used_r} + {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cfg_tot_r <= CntW'(MaxPages);
      cfg_res_r <= CntW'(1);
      used_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CfgTotal) cfg_tot_r <= cfg_data;
        else cfg_res_r <= cfg_data;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AddrW+1)'(MapWords - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r <= in_word.req_type;
            pidx_r <= in_word.page_index;
            cnt_r <= in_word.num_pages;
            tot_r <= tot_eff;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          st_r <= StDone;
          rpage_r <= '0;
          pused_r <= 1'b0;
          run_r <= '0;
          wb_dirty_r <= 1'b0;
          state_r <= S_DONE;
          case (req_r)
            ReqAlloc: begin
              if (cnt_r == '0 || cnt_r > tot_r) st_r <= StRej;
              else begin
                phase_r <= P_SCAN; p_r <= '0; stop_r <= tot_r; state_r <= S_RD;
              end
            end
            ReqFind: begin
              st_r <= StNone;
              if (tot_r != '0) begin
                phase_r <= P_SCAN; p_r <= '0; stop_r <= tot_r; state_r <= S_RD;
              end
            end
            ReqFree: begin
              if (pidx_r == '0 || cnt_r == '0 || {1'b0, pidx_r} >= tot_r ||
                  cnt_r > tot_r - {1'b0, pidx_r}) st_r <= StRej;
              else begin
                phase_r <= P_FREE; p_r <= {1'b0, pidx_r};
                stop_r <= {1'b0, pidx_r} + cnt_r; state_r <= S_RD;
              end
            end
            ReqTest: begin
              if ({1'b0, pidx_r} >= tot_r) pused_r <= 1'b1;
              else begin
                phase_r <= P_TEST; p_r <= {1'b0, pidx_r}; state_r <= S_RD;
              end
            end
            ReqInit: begin
              clr_r <= '0; state_r <= S_FILL;
            end
            default: st_r <= StRej;
          endcase
        end
        S_FILL: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AddrW+1)'(MapWords - 1)) begin
            used_r <= res_eff; state_r <= S_DONE;
          end
        end
        S_RD: begin
          wb_addr_r <= p_r[BitW +: AddrW];
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          word_r <= ram_rdata;
          wb_dirty_r <= 1'b0;
          state_r <= S_BIT;
        end
        S_BIT: begin
          state_r <= S_BIT;
          case (phase_r)
            P_TEST: begin
              pused_r <= cur_bit; state_r <= S_DONE;
            end
            P_SCAN: begin
              if (!cur_bit) begin
                if (req_r == ReqFind) begin
                  rpage_r <= p_r[PageW-1:0]; st_r <= StDone; state_r <= S_DONE;
                end else begin
                  if (run_r == '0) rpage_r <= p_r[PageW-1:0];
                  run_r <= run_r + 1'b1;
                  if (run_r + 1'b1 == cnt_r) begin
                    phase_r <= P_MARK;
                    p_r <= (run_r == '0) ? p_r : {1'b0, rpage_r};
                    stop_r <= ((run_r == '0) ? p_r : {1'b0, rpage_r}) + cnt_r;
                    state_r <= S_RD;
                  end
                end
              end else run_r <= '0;
              if (state_r == S_BIT && !(run_r + 1'b1 == cnt_r && !cur_bit) &&
                  !(req_r == ReqFind && !cur_bit)) begin
                p_r <= p_r + 1'b1;
                if (p_r + 1'b1 == stop_r) begin
                  if (req_r == ReqAlloc) begin
                    st_r <= StNone; rpage_r <= '0;
                  end
                  state_r <= S_DONE;
                end else if (bsel == BitW'(WordBits - 1)) state_r <= S_RD;
              end
            end
            default: begin
              if (phase_r == P_MARK) begin
                word_r[bsel] <= 1'b1;
              end else if (cur_bit) begin
                word_r[bsel] <= 1'b0;
                if (used_r != '0) used_r <= used_r - 1'b1;
              end
              wb_dirty_r <= 1'b1;
              p_r <= p_r + 1'b1;
              if (p_r + 1'b1 == stop_r || bsel == BitW'(WordBits - 1)) state_r <= S_WB;
            end
          endcase
        end
        S_WB: begin
          if (p_r == stop_r) begin
            if (phase_r == P_MARK)
              used_r <= sum_w[CntW] ? {CntW{1'b1}} : sum_w[CntW-1:0];
            state_r <= S_DONE;
          end else state_r <= S_RD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_word.status <= st_r;
          out_word.result_page <= rpage_r;
          out_word.page_used <= pused_r;
          out_word.used_count <= used_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### design/bpa_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### sim/testbench.sv
// Testbench for the bitmap page allocator: scoreboard against a behavioral map model.
`timescale 1ns / 1ps
module testbench;
  import bpa_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_valid;
  out_word_t out_word;
  logic cfg_we;
  logic cfg_index;
  logic [CntW-1:0] cfg_data;

  bitmap_page_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int WatchdogLimit = 40000;

  bit [MaxPages-1:0] page_map;
  int used_total;
  int total_cfg;
  int reserved_cfg;

  in_word_t request_queue[$];
  out_word_t pending_results[$];
  int errors;
  int accepted;
  int checked;
  int gap_left;
  int burst_left;
  int stall_cycles;
  int phases;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_total();
    return (total_cfg > MaxPages) ? MaxPages : total_cfg;
  endfunction

  // Behavioral map: computes the response word and updates the map and count.
  function automatic out_word_t serve_request(in_word_t w);
    int tot;
    int cnt;
    int pg;
    int run;
    int first;
    int r;
    bit found;
    out_word_t o;
    tot = eff_total();
    cnt = w.num_pages;
    pg = w.page_index;
    o = '0;
    o.status = StDone;
    case (w.req_type)
      ReqAlloc: begin
        if (cnt == 0 || cnt > tot) begin
          o.status = StRej;
        end else begin
          run = 0;
          first = 0;
          found = 1'b0;
          for (int p = 0; p < tot && !found; p++) begin
            if (!page_map[p]) begin
              if (run == 0) first = p;
              run++;
              if (run == cnt) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (int i = 0; i < cnt; i++) page_map[first+i] = 1'b1;
            used_total += cnt;
            if (used_total > 8191) used_total = 8191;
            o.result_page = first[PageW-1:0];
          end else begin
            o.status = StNone;
          end
        end
      end
      ReqFree: begin
        if (pg == 0 || cnt == 0 || pg >= tot || cnt > tot - pg) begin
          o.status = StRej;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (page_map[pg+i]) begin
              page_map[pg+i] = 1'b0;
              if (used_total > 0) used_total--;
            end
          end
        end
      end
      ReqTest: o.page_used = (pg >= tot) ? 1'b1 : page_map[pg];
      ReqFind: begin
        o.status = StNone;
        for (int p = 0; p < tot; p++) begin
          if (!page_map[p]) begin
            o.result_page = p[PageW-1:0];
            o.status = StDone;
            break;
          end
        end
      end
      ReqInit: begin
        r = (reserved_cfg > MaxPages) ? MaxPages : reserved_cfg;
        page_map = '0;
        for (int p = 0; p < r && p < tot; p++) page_map[p] = 1'b1;
        used_total = r;
      end
      default: o.status = StRej;
    endcase
    o.used_count = used_total[CntW-1:0];
    return o;
  endfunction

  function automatic in_word_t mk_req(logic [2:0] t, int pg, int cnt);
    in_word_t w;
    w.req_type = t;
    w.page_index = pg[PageW-1:0];
    w.num_pages = cnt[CntW-1:0];
    return w;
  endfunction

  function automatic int pick_count(int tot);
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 85) return $urandom_range(1, (tot > 1) ? tot : 1);
    if (r < 92) return 0;
    return $urandom_range(8191);
  endfunction

  function automatic in_word_t random_request();
    int tot;
    int r;
    int pg;
    tot = eff_total();
    r = $urandom_range(99);
    pg = (tot > 0 && $urandom_range(9) != 0) ? $urandom_range(tot - 1) : $urandom_range(4095);
    if (r < 36) return mk_req(ReqAlloc, $urandom_range(4095), pick_count(tot));
    if (r < 62) return mk_req(ReqFree, pg, pick_count(tot));
    if (r < 78) return mk_req(ReqTest, pg, $urandom_range(8191));
    if (r < 90) return mk_req(ReqFind, $urandom_range(4095), $urandom_range(8191));
    if (r < 96) return mk_req(ReqInit, $urandom_range(4095), $urandom_range(8191));
    return mk_req(3'($urandom_range(5, 7)), $urandom_range(4095), $urandom_range(8191));
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) burst_left = $urandom_range(10, 40);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 90);
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(serve_request(in_word));
        accepted++;
        gap_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_word <= request_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_word);
        errors++;
      end else begin
        exp_w = pending_results.pop_front();
        checked++;
        if (out_word.status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_w.status, out_word.status);
          errors++;
        end
        if (out_word.result_page !== exp_w.result_page) begin
          $display("%0t: result_page expected %0d actual %0d", $time, exp_w.result_page,
                   out_word.result_page);
          errors++;
        end
        if (out_word.page_used !== exp_w.page_used) begin
          $display("%0t: page_used expected %0d actual %0d", $time, exp_w.page_used,
                   out_word.page_used);
          errors++;
        end
        if (out_word.used_count !== exp_w.used_count) begin
          $display("%0t: used_count expected %0d actual %0d", $time, exp_w.used_count,
                   out_word.used_count);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic drain();
    do @(posedge clk);
    while (request_queue.size() != 0 || pending_results.size() != 0 || start || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(int tot, int res, int n);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CfgTotal;
    cfg_data <= tot[CntW-1:0];
    @(posedge clk);
    cfg_index <= CfgReserved;
    cfg_data <= res[CntW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    total_cfg = tot;
    reserved_cfg = res;
    phases++;
    request_queue.push_back(mk_req(ReqInit, 0, 0));
    for (int i = 0; i < n; i++) request_queue.push_back(random_request());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CfgTotal;
    cfg_data = '0;
    page_map = '0;
    used_total = 0;
    total_cfg = 4096;
    reserved_cfg = 1;
    errors = 0;
    accepted = 0;
    checked = 0;
    gap_left = 0;
    burst_left = 0;
    stall_cycles = 0;
    phases = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, default config
    request_queue.push_back(mk_req(ReqTest, 0, 0));
    request_queue.push_back(mk_req(ReqFind, 0, 0));
    request_queue.push_back(mk_req(ReqInit, 0, 0));
    request_queue.push_back(mk_req(ReqFind, 4095, 8191));
    request_queue.push_back(mk_req(ReqAlloc, 0, 1));
    request_queue.push_back(mk_req(ReqAlloc, 0, 0));
    request_queue.push_back(mk_req(ReqAlloc, 0, 4097));
    request_queue.push_back(mk_req(ReqAlloc, 0, 8191));
    request_queue.push_back(mk_req(ReqAlloc, 4095, 4096));
    request_queue.push_back(mk_req(ReqTest, 1, 0));
    request_queue.push_back(mk_req(ReqTest, 4095, 0));
    request_queue.push_back(mk_req(ReqFree, 0, 1));
    request_queue.push_back(mk_req(ReqFree, 1, 0));
    request_queue.push_back(mk_req(ReqFree, 4095, 2));
    request_queue.push_back(mk_req(ReqFree, 4095, 1));
    request_queue.push_back(mk_req(ReqFree, 1, 4095));
    request_queue.push_back(mk_req(ReqFree, 1, 5));
    request_queue.push_back(mk_req(ReqAlloc, 0, 4094));
    request_queue.push_back(mk_req(ReqFind, 0, 0));
    request_queue.push_back(mk_req(3'd5, 4095, 8191));
    request_queue.push_back(mk_req(3'd7, 0, 0));
    request_queue.push_back(mk_req(ReqTest, 4095, 0));

    run_phase(64, 3, 500);
    run_phase(100, 0, 380);
    run_phase(0, 5, 40);
    run_phase(33, 200, 250);
    run_phase(8191, 8191, 12);
    run_phase(4096, 4096, 15);
    run_phase(160, 17, 450);
    run_phase(1, 1, 50);
    run_phase(31, 2, 150);
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d requests over %0d register settings, %0d responses checked.",
             accepted, phases + 1, checked);
    $display("Requests: alloc/free/test/find/init/unknown, incl. zero and oversize counts.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
